>>> rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// Frame colour density package
// Types, constants and helper functions shared by the frame colour density
// block: pixel and result payloads, configuration, frame snapshots.
// ----------------------------------------------------------------------------
package fcd_pkg;

   localparam int MaxColumns     = 4096;
   localparam int MaxRows        = 4096;

   localparam int PixWidth       = 8;
   localparam int SizeWidth      = 13;
   localparam int CoordWidth     = 12;
   localparam int SumWidth       = 32;
   localparam int TotalWidth     = SumWidth + 2;
   localparam int ShareWidth     = 15;
   localparam int ThrWidth       = 15;
   localparam int ShareScale     = 25600;
   localparam int ProdWidth      = SumWidth + ShareWidth;
   localparam int DivWidth       = TotalWidth + ShareWidth - 1;
   localparam int StepWidth      = $clog2(ShareWidth);
   localparam int SpanRowsWidth  = 2 * CoordWidth;
   localparam int DenomWidth     = SpanRowsWidth + 2;
   localparam int RhsWidth       = ThrWidth + DenomWidth;

   localparam int Div5InWidth    = SizeWidth + 1;
   localparam int Div5Shift      = 16;
   localparam int Recip5         = (1 << Div5Shift) / 5 + 1;
   localparam int Div5ProdWidth  = Div5InWidth + Div5Shift;

   localparam int SnapDepth      = 2;
   localparam int SnapPtrWidth   = $clog2(SnapDepth);
   localparam int SnapCountWidth = $clog2(SnapDepth + 1);

   localparam int CsrAddrWidth   = 4;
   localparam int CsrDataWidth   = 32;
   localparam int RegIndexWidth  = CsrAddrWidth - 2;

   localparam logic [SizeWidth-1:0] ResetWidth     = SizeWidth'(640);
   localparam logic [SizeWidth-1:0] ResetHeight    = SizeWidth'(480);
   localparam logic [ThrWidth-1:0]  ResetThreshold = ThrWidth'(2560);

   typedef enum logic [RegIndexWidth-1:0] {
      REG_WIDTH     = 2'd0,
      REG_HEIGHT    = 2'd1,
      REG_THRESHOLD = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      CH_RED    = 2'd0,
      CH_GREEN  = 2'd1,
      CH_BLUE   = 2'd2,
      CH_WINDOW = 2'd3
   } chan_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DEN,
      BK_RHS,
      BK_CMP,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [PixWidth-1:0] red;
      logic [PixWidth-1:0] green;
      logic [PixWidth-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [ShareWidth-1:0] red_share;
      logic [ShareWidth-1:0] green_share;
      logic [ShareWidth-1:0] blue_share;
      logic                  green_centered;
   } result_type;

   typedef struct packed {
      logic [SizeWidth-1:0]  width;
      logic [SizeWidth-1:0]  height;
      logic [CoordWidth-1:0] win_start;
      logic [CoordWidth-1:0] win_end;
      logic [CoordWidth-1:0] win_rows;
      logic [ThrWidth-1:0]   threshold;
   } cfg_type;

   typedef struct packed {
      logic [SumWidth-1:0]   red_total;
      logic [SumWidth-1:0]   green_total;
      logic [SumWidth-1:0]   blue_total;
      logic [SumWidth-1:0]   window_total;
      logic [CoordWidth-1:0] win_span;
      logic [CoordWidth-1:0] win_rows;
      logic [ThrWidth-1:0]   threshold;
   } snap_type;

   function automatic logic [SizeWidth-1:0] clamp_size(input logic [SizeWidth-1:0] v,
                                                       input logic [SizeWidth-1:0] maxv);
      logic [SizeWidth-1:0] r;
      r = v;
      if (v == '0) begin
         r = SizeWidth'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   function automatic logic [CoordWidth-1:0] div5(input logic [Div5InWidth-1:0] x);
      logic [Div5ProdWidth-1:0] p;
      p = Div5ProdWidth'(x) * Div5ProdWidth'(Recip5);
      return p[Div5Shift +: CoordWidth];
   endfunction

   function automatic logic [SumWidth-1:0] sat_add(input logic [SumWidth-1:0] a,
                                                   input logic [PixWidth-1:0] b);
      logic [SumWidth:0] s;
      s = {1'b0, a} + (SumWidth + 1)'(b);
      return s[SumWidth] ? '1 : s[SumWidth-1:0];
   endfunction

endpackage

>>> rtl/fcd_csr.sv
// ----------------------------------------------------------------------------
// Frame colour density register file
// Holds frame size and threshold, and the window bounds derived from them.
// ----------------------------------------------------------------------------
module fcd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fcd_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [fcd_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [fcd_pkg::CsrDataWidth-1:0]  prdata,
   output logic                              pready,
   output fcd_pkg::cfg_type                  cfg
);

   logic [fcd_pkg::SizeWidth-1:0]  width_raw_ff, width_raw_in;
   logic [fcd_pkg::SizeWidth-1:0]  height_raw_ff, height_raw_in;
   logic [fcd_pkg::ThrWidth-1:0]   thr_ff, thr_in;
   logic [fcd_pkg::SizeWidth-1:0]  width_ff, width_in;
   logic [fcd_pkg::SizeWidth-1:0]  height_ff, height_in;
   logic [fcd_pkg::CoordWidth-1:0] win_start_ff, win_start_in;
   logic [fcd_pkg::CoordWidth-1:0] win_end_ff, win_end_in;
   logic [fcd_pkg::CoordWidth-1:0] win_rows_ff, win_rows_in;

   fcd_pkg::reg_index_type         index;
   logic                           wr_en;
   logic [fcd_pkg::SizeWidth-1:0]  wr_size;
   logic [fcd_pkg::SizeWidth-1:0]  new_width;
   logic [fcd_pkg::SizeWidth-1:0]  new_height;

   assign index  = fcd_pkg::reg_index_type'(paddr[fcd_pkg::CsrAddrWidth-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      wr_size       = pwdata[fcd_pkg::SizeWidth-1:0];
      new_width     = fcd_pkg::clamp_size(wr_size, fcd_pkg::SizeWidth'(fcd_pkg::MaxColumns));
      new_height    = fcd_pkg::clamp_size(wr_size, fcd_pkg::SizeWidth'(fcd_pkg::MaxRows));
      width_raw_in  = width_raw_ff;
      height_raw_in = height_raw_ff;
      thr_in        = thr_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      win_start_in  = win_start_ff;
      win_end_in    = win_end_ff;
      win_rows_in   = win_rows_ff;
      if (wr_en) begin
         case (index)
            fcd_pkg::REG_WIDTH: begin
               width_raw_in = wr_size;
               width_in     = new_width;
               win_start_in = fcd_pkg::div5({new_width, 1'b0});
               win_end_in   = fcd_pkg::div5({new_width, 1'b0} +
                                            fcd_pkg::Div5InWidth'(new_width));
            end
            fcd_pkg::REG_HEIGHT: begin
               height_raw_in = wr_size;
               height_in     = new_height;
               win_rows_in   = fcd_pkg::div5({new_height, 1'b0} +
                                             fcd_pkg::Div5InWidth'(new_height));
            end
            fcd_pkg::REG_THRESHOLD: begin
               thr_in = pwdata[fcd_pkg::ThrWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= fcd_pkg::ResetWidth;
         height_raw_ff <= fcd_pkg::ResetHeight;
         thr_ff        <= fcd_pkg::ResetThreshold;
         width_ff      <= fcd_pkg::ResetWidth;
         height_ff     <= fcd_pkg::ResetHeight;
         win_start_ff  <= fcd_pkg::div5({fcd_pkg::ResetWidth, 1'b0});
         win_end_ff    <= fcd_pkg::div5({fcd_pkg::ResetWidth, 1'b0} +
                                        fcd_pkg::Div5InWidth'(fcd_pkg::ResetWidth));
         win_rows_ff   <= fcd_pkg::div5({fcd_pkg::ResetHeight, 1'b0} +
                                        fcd_pkg::Div5InWidth'(fcd_pkg::ResetHeight));
      end else begin
         width_raw_ff  <= width_raw_in;
         height_raw_ff <= height_raw_in;
         thr_ff        <= thr_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         win_start_ff  <= win_start_in;
         win_end_ff    <= win_end_in;
         win_rows_ff   <= win_rows_in;
      end
   end

   always_comb begin
      case (index)
         fcd_pkg::REG_WIDTH:     prdata = fcd_pkg::CsrDataWidth'(width_raw_ff);
         fcd_pkg::REG_HEIGHT:    prdata = fcd_pkg::CsrDataWidth'(height_raw_ff);
         fcd_pkg::REG_THRESHOLD: prdata = fcd_pkg::CsrDataWidth'(thr_ff);
         default:                prdata = '0;
      endcase
   end

   assign cfg = '{width:     width_ff,
                  height:    height_ff,
                  win_start: win_start_ff,
                  win_end:   win_end_ff,
                  win_rows:  win_rows_ff,
                  threshold: thr_ff};

endmodule

>>> rtl/fcd_front.sv
// ----------------------------------------------------------------------------
// Frame colour density front end
// Accepts pixels, tracks position and accumulates the frame sums; hands a
// snapshot of the sums to the back end at the end of each frame.
// ----------------------------------------------------------------------------
module fcd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  fcd_pkg::pixel_type  req_data,
   input  fcd_pkg::cfg_type    cfg,
   input  logic                snap_full,
   output logic                snap_push,
   output fcd_pkg::snap_type   snap
);

   logic [fcd_pkg::SumWidth-1:0]   red_ff, red_in;
   logic [fcd_pkg::SumWidth-1:0]   green_ff, green_in;
   logic [fcd_pkg::SumWidth-1:0]   blue_ff, blue_in;
   logic [fcd_pkg::SumWidth-1:0]   win_ff, win_in;
   logic [fcd_pkg::CoordWidth-1:0] col_ff, col_in;
   logic [fcd_pkg::CoordWidth-1:0] row_ff, row_in;

   logic                           accept;
   logic [fcd_pkg::SizeWidth-1:0]  col_p1;
   logic [fcd_pkg::SizeWidth-1:0]  row_p1;
   logic                           row_done;
   logic                           frame_done;
   logic                           in_window;
   logic [fcd_pkg::SumWidth-1:0]   red_sum;
   logic [fcd_pkg::SumWidth-1:0]   green_sum;
   logic [fcd_pkg::SumWidth-1:0]   blue_sum;
   logic [fcd_pkg::SumWidth-1:0]   win_sum;

   assign full   = snap_full;
   assign accept = push && !snap_full;

   always_comb begin
      col_p1     = fcd_pkg::SizeWidth'(col_ff) + fcd_pkg::SizeWidth'(1);
      row_p1     = fcd_pkg::SizeWidth'(row_ff) + fcd_pkg::SizeWidth'(1);
      row_done   = col_p1 >= cfg.width;
      frame_done = row_done && (row_p1 >= cfg.height);
      in_window  = (col_ff >= cfg.win_start) && (col_ff <= cfg.win_end) &&
                   (row_ff < cfg.win_rows);
      red_sum    = fcd_pkg::sat_add(red_ff, req_data.red);
      green_sum  = fcd_pkg::sat_add(green_ff, req_data.green);
      blue_sum   = fcd_pkg::sat_add(blue_ff, req_data.blue);
      win_sum    = in_window ? fcd_pkg::sat_add(win_ff, req_data.green) : win_ff;

      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      win_in   = win_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (frame_done) begin
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
            win_in   = '0;
            col_in   = '0;
            row_in   = '0;
         end else begin
            red_in   = red_sum;
            green_in = green_sum;
            blue_in  = blue_sum;
            win_in   = win_sum;
            if (row_done) begin
               col_in = '0;
               row_in = row_p1[fcd_pkg::CoordWidth-1:0];
            end else begin
               col_in = col_p1[fcd_pkg::CoordWidth-1:0];
            end
         end
      end

      snap_push = accept && frame_done;
      snap      = '{red_total:    red_sum,
                    green_total:  green_sum,
                    blue_total:   blue_sum,
                    window_total: win_sum,
                    win_span:     cfg.win_end - cfg.win_start,
                    win_rows:     cfg.win_rows,
                    threshold:    cfg.threshold};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         win_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         win_ff   <= win_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   a_snap_room: assert property (@(posedge clock) disable iff (reset)
      snap_push |-> !snap_full)
      else $error("Frame snapshot pushed into a full queue.");

endmodule

>>> rtl/fcd_queue.sv
// ----------------------------------------------------------------------------
// Frame colour density snapshot queue
// Short queue of finished frame sums between the front and back ends.
// ----------------------------------------------------------------------------
module fcd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  fcd_pkg::snap_type  wr_data,
   output logic               full,
   input  logic               rd_en,
   output fcd_pkg::snap_type  rd_data,
   output logic               empty
);

   fcd_pkg::snap_type                  mem_ff [fcd_pkg::SnapDepth];
   logic [fcd_pkg::SnapPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [fcd_pkg::SnapPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [fcd_pkg::SnapCountWidth-1:0] count_ff, count_in;

   logic do_write;
   logic do_read;

   assign full     = count_ff == fcd_pkg::SnapCountWidth'(fcd_pkg::SnapDepth);
   assign empty    = count_ff == '0;
   assign do_write = wr_en && !full;
   assign do_read  = rd_en && !empty;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == fcd_pkg::SnapPtrWidth'(fcd_pkg::SnapDepth - 1)) ?
                     '0 : wr_ptr_ff + fcd_pkg::SnapPtrWidth'(1);
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == fcd_pkg::SnapPtrWidth'(fcd_pkg::SnapDepth - 1)) ?
                     '0 : rd_ptr_ff + fcd_pkg::SnapPtrWidth'(1);
      end
      if (do_write && !do_read) begin
         count_in = count_ff + fcd_pkg::SnapCountWidth'(1);
      end else if (do_read && !do_write) begin
         count_in = count_ff - fcd_pkg::SnapCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fcd_pkg::SnapCountWidth'(fcd_pkg::SnapDepth))
      else $error("Snapshot queue count exceeds its depth.");

endmodule

>>> rtl/fcd_back.sv
// ----------------------------------------------------------------------------
// Frame colour density back end
// Turns a frame snapshot into channel shares with a shared multiplier and a
// restoring divider, decides the centre green flag, and holds the result.
// ----------------------------------------------------------------------------
module fcd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                snap_empty,
   input  fcd_pkg::snap_type   snap_data,
   output logic                snap_pop,
   output logic                empty,
   input  logic                pop,
   output fcd_pkg::result_type rsp_data
);

   fcd_pkg::back_state_type           state_ff, state_in;
   fcd_pkg::snap_type                 snap_ff, snap_in;
   fcd_pkg::chan_type                 chan_ff, chan_in;
   logic [fcd_pkg::TotalWidth-1:0]    total_ff, total_in;
   logic [fcd_pkg::DivWidth-1:0]      rem_ff, rem_in;
   logic [fcd_pkg::DivWidth-1:0]      div_ff, div_in;
   logic [fcd_pkg::ShareWidth-1:0]    quot_ff, quot_in;
   logic [fcd_pkg::StepWidth-1:0]     step_ff, step_in;
   logic [fcd_pkg::ShareWidth-1:0]    red_share_ff, red_share_in;
   logic [fcd_pkg::ShareWidth-1:0]    green_share_ff, green_share_in;
   logic [fcd_pkg::ShareWidth-1:0]    blue_share_ff, blue_share_in;
   logic [fcd_pkg::SpanRowsWidth-1:0] span_rows_ff, span_rows_in;
   logic [fcd_pkg::DenomWidth-1:0]    denom_ff, denom_in;
   logic [fcd_pkg::RhsWidth-1:0]      rhs_ff, rhs_in;
   logic                              flag_ff, flag_in;
   logic                              out_valid_ff, out_valid_in;
   fcd_pkg::result_type               out_data_ff, out_data_in;

   logic [fcd_pkg::SumWidth-1:0]      mul_a;
   logic [fcd_pkg::ProdWidth-1:0]     product;
   logic                              ge;
   logic [fcd_pkg::DivWidth-1:0]      diff;
   logic [fcd_pkg::ShareWidth-1:0]    quot_next;
   logic [fcd_pkg::ShareWidth-1:0]    share;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_data_ff;

   always_comb begin
      case (chan_ff)
         fcd_pkg::CH_RED:    mul_a = snap_ff.red_total;
         fcd_pkg::CH_GREEN:  mul_a = snap_ff.green_total;
         fcd_pkg::CH_BLUE:   mul_a = snap_ff.blue_total;
         fcd_pkg::CH_WINDOW: mul_a = snap_ff.window_total;
         default:            mul_a = '0;
      endcase
      product   = fcd_pkg::ProdWidth'(mul_a) * fcd_pkg::ProdWidth'(fcd_pkg::ShareScale);
      ge        = rem_ff >= div_ff;
      diff      = rem_ff - div_ff;
      quot_next = {quot_ff[fcd_pkg::ShareWidth-2:0], ge};
      share     = (total_ff == '0) ? '0 : quot_next;

      state_in       = state_ff;
      snap_in        = snap_ff;
      chan_in        = chan_ff;
      total_in       = total_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      quot_in        = quot_ff;
      step_in        = step_ff;
      red_share_in   = red_share_ff;
      green_share_in = green_share_ff;
      blue_share_in  = blue_share_ff;
      span_rows_in   = span_rows_ff;
      denom_in       = denom_ff;
      rhs_in         = rhs_ff;
      flag_in        = flag_ff;
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      snap_pop       = 1'b0;

      if (out_valid_ff && pop) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         fcd_pkg::BK_IDLE: begin
            if (!snap_empty) begin
               snap_pop = 1'b1;
               snap_in  = snap_data;
               total_in = fcd_pkg::TotalWidth'(snap_data.red_total) +
                          fcd_pkg::TotalWidth'(snap_data.green_total) +
                          fcd_pkg::TotalWidth'(snap_data.blue_total);
               chan_in  = fcd_pkg::CH_RED;
               state_in = fcd_pkg::BK_MUL;
            end
         end
         fcd_pkg::BK_MUL: begin
            rem_in  = fcd_pkg::DivWidth'(product);
            div_in  = {total_ff, {(fcd_pkg::ShareWidth - 1){1'b0}}};
            quot_in = '0;
            step_in = '0;
            if (chan_ff == fcd_pkg::CH_WINDOW) begin
               span_rows_in = fcd_pkg::SpanRowsWidth'(snap_ff.win_span) *
                              fcd_pkg::SpanRowsWidth'(snap_ff.win_rows);
               state_in     = fcd_pkg::BK_DEN;
            end else begin
               state_in = fcd_pkg::BK_DIV;
            end
         end
         fcd_pkg::BK_DIV: begin
            rem_in  = ge ? diff : rem_ff;
            div_in  = div_ff >> 1;
            quot_in = quot_next;
            step_in = step_ff + fcd_pkg::StepWidth'(1);
            if (step_ff == fcd_pkg::StepWidth'(fcd_pkg::ShareWidth - 1)) begin
               state_in = fcd_pkg::BK_MUL;
               case (chan_ff)
                  fcd_pkg::CH_RED: begin
                     red_share_in = share;
                     chan_in      = fcd_pkg::CH_GREEN;
                  end
                  fcd_pkg::CH_GREEN: begin
                     green_share_in = share;
                     chan_in        = fcd_pkg::CH_BLUE;
                  end
                  default: begin
                     blue_share_in = share;
                     chan_in       = fcd_pkg::CH_WINDOW;
                  end
               endcase
            end
         end
         fcd_pkg::BK_DEN: begin
            denom_in = fcd_pkg::DenomWidth'({span_rows_ff, 1'b0}) +
                       fcd_pkg::DenomWidth'(span_rows_ff);
            state_in = fcd_pkg::BK_RHS;
         end
         fcd_pkg::BK_RHS: begin
            rhs_in   = fcd_pkg::RhsWidth'(snap_ff.threshold) * fcd_pkg::RhsWidth'(denom_ff);
            state_in = fcd_pkg::BK_CMP;
         end
         fcd_pkg::BK_CMP: begin
            flag_in  = (denom_ff != '0) && (rem_ff > fcd_pkg::DivWidth'(rhs_ff));
            state_in = fcd_pkg::BK_DONE;
         end
         fcd_pkg::BK_DONE: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               out_data_in  = '{red_share:      red_share_ff,
                                green_share:    green_share_ff,
                                blue_share:     blue_share_ff,
                                green_centered: flag_ff};
               state_in     = fcd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = fcd_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff        <= snap_in;
      chan_ff        <= chan_in;
      total_ff       <= total_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      quot_ff        <= quot_in;
      step_ff        <= step_in;
      red_share_ff   <= red_share_in;
      green_share_ff <= green_share_in;
      blue_share_ff  <= blue_share_in;
      span_rows_ff   <= span_rows_in;
      denom_ff       <= denom_in;
      rhs_ff         <= rhs_in;
      flag_ff        <= flag_in;
      out_data_ff    <= out_data_in;
   end

   a_share_sum: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (17'(out_data_ff.red_share) + 17'(out_data_ff.green_share) +
                        17'(out_data_ff.blue_share)) <= 17'(fcd_pkg::ShareScale))
      else $error("Channel shares add up to more than one hundred percent.");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcd_pkg::BK_DIV |->
         step_ff <= fcd_pkg::StepWidth'(fcd_pkg::ShareWidth - 1))
      else $error("Divider ran past its last quotient bit.");

endmodule

>>> rtl/frame_color_density_top.sv
// ----------------------------------------------------------------------------
// Frame colour density top level
// Takes one RGB pixel per transfer in raster order, with the frame width and
// height set in registers, and keeps the column and row itself. Sums of red,
// green and blue over the frame, and of green inside the centre window, are
// kept as the pixels arrive. On the last pixel of a frame the sums are queued,
// and the back end works out each channel's share and the centre green flag.
// There is one result per frame. A pixel is taken on every cycle that full is
// low. Each of the three channels takes a multiply step and fifteen divide
// steps. The window test then passes through the multiply, denominator,
// right-hand side and compare states, and the result is loaded in the done
// state. Two finished frames can wait in the snapshot queue, behind the one in
// the back end and the one in the result register. Full therefore rises only
// when frames end faster than the back end works them off, or when results
// are not taken.
// ----------------------------------------------------------------------------
module frame_color_density_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  fcd_pkg::pixel_type               req_data,
   output logic                             empty,
   input  logic                             pop,
   output fcd_pkg::result_type              rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fcd_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [fcd_pkg::CsrDataWidth-1:0] pwdata,
   output logic [fcd_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready
);

   fcd_pkg::cfg_type  cfg;
   fcd_pkg::snap_type snap_wr;
   fcd_pkg::snap_type snap_rd;
   logic              snap_push;
   logic              snap_full;
   logic              snap_pop;
   logic              snap_empty;

   fcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cfg       (cfg),
      .snap_full (snap_full),
      .snap_push (snap_push),
      .snap      (snap_wr)
   );

   fcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (snap_push),
      .wr_data (snap_wr),
      .full    (snap_full),
      .rd_en   (snap_pop),
      .rd_data (snap_rd),
      .empty   (snap_empty)
   );

   fcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_empty (snap_empty),
      .snap_data  (snap_rd),
      .snap_pop   (snap_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Frame colour density testbench
// Streams RGB pixels into frame_color_density_top under a range of frame
// sizes and thresholds, written over the register port while the block is
// idle. A local model of the block tracks the frame position and the channel
// sums, and predicts the colour shares and the centre green flag at the end
// of each frame. Every result transfer is checked field by field against the
// oldest prediction. Both sides pause at random, and the result side holds
// off once for long enough that the block fills and stops taking pixels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fcd_pkg::*;

   localparam int ClockPeriod    = 10;
   localparam int ResetCycles    = 6;
   localparam int SettleCycles   = 200;
   localparam int LongHoldCycles = 800;
   localparam int RandomItems    = 900;
   localparam int TimeoutCycles  = 1_000_000;
   localparam logic [RegIndexWidth-1:0] RegSpare = 2'd3;

   typedef enum int {
      MIX_RANDOM,
      MIX_DIM_GREEN,
      MIX_DARK,
      MIX_BRIGHT
   } pixel_mix_type;

   logic                    clock   = 1'b0;
   logic                    reset   = 1'b1;
   logic                    push    = 1'b0;
   logic                    full;
   pixel_type               req_data = '0;
   logic                    empty;
   logic                    pop     = 1'b0;
   result_type              rsp_data;
   logic                    psel    = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] paddr   = '0;
   logic [CsrDataWidth-1:0] pwdata  = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   frame_color_density_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #(ClockPeriod / 2) clock = 1'b1;
      #(ClockPeriod / 2) clock = 1'b0;
   end

   // Local copy of the block's registers and frame state.
   logic [SizeWidth-1:0]  cfg_width     = ResetWidth;
   logic [SizeWidth-1:0]  cfg_height    = ResetHeight;
   logic [ThrWidth-1:0]   cfg_threshold = ResetThreshold;
   logic [SumWidth-1:0]   red_sum          = '0;
   logic [SumWidth-1:0]   green_sum        = '0;
   logic [SumWidth-1:0]   blue_sum         = '0;
   logic [SumWidth-1:0]   centre_green_sum = '0;
   logic [CoordWidth-1:0] column_at        = '0;
   logic [CoordWidth-1:0] row_at           = '0;

   pixel_type  pixel_backlog[$];
   result_type frame_results_due[$];
   result_type oldest_due;
   int         mismatch_count = 0;

   bit send_idle_on  = 1'b1;
   bit take_idle_on  = 1'b1;
   int send_wait     = 0;
   int take_wait     = 0;
   bit stall_request = 1'b0;
   int hold_left     = 0;
   logic sink_hold;

   assign sink_hold = (hold_left != 0);

   function automatic logic [SizeWidth-1:0] bounded_size(input logic [SizeWidth-1:0] v,
                                                        input int limit);
      if (v == '0) return SizeWidth'(1);
      if (v > limit) return SizeWidth'(limit);
      return v;
   endfunction

   function automatic logic [SumWidth-1:0] add_saturating(input logic [SumWidth-1:0] a,
                                                         input logic [PixWidth-1:0] b);
      logic [SumWidth:0] s;
      s = {1'b0, a} + (SumWidth + 1)'(b);
      return s[SumWidth] ? '1 : s[SumWidth-1:0];
   endfunction

   function automatic logic [ShareWidth-1:0] percent_of(input logic [SumWidth-1:0] part,
                                                       input logic [TotalWidth-1:0] total);
      logic [63:0] q;
      if (total == '0) return '0;
      q = (64'(part) * 64'(ShareScale)) / 64'(total);
      return q[ShareWidth-1:0];
   endfunction

   task automatic account_pixel(input pixel_type px);
      int unsigned            w;
      int unsigned            h;
      int unsigned            win_first;
      int unsigned            win_last;
      int unsigned            win_rows;
      logic [TotalWidth-1:0]  total;
      logic [63:0]            denom;
      logic [63:0]            lhs;
      logic [63:0]            rhs;
      result_type             outcome;
      w = 32'(bounded_size(cfg_width, MaxColumns));
      h = 32'(bounded_size(cfg_height, MaxRows));
      win_first = (2 * w) / 5;
      win_last  = (3 * w) / 5;
      win_rows  = (3 * h) / 5;
      red_sum   = add_saturating(red_sum, px.red);
      green_sum = add_saturating(green_sum, px.green);
      blue_sum  = add_saturating(blue_sum, px.blue);
      if (column_at >= win_first && column_at <= win_last && row_at < win_rows) begin
         centre_green_sum = add_saturating(centre_green_sum, px.green);
      end
      if (column_at + 1 < w) begin
         column_at = column_at + 1'b1;
         return;
      end
      column_at = '0;
      if (row_at + 1 < h) begin
         row_at = row_at + 1'b1;
         return;
      end
      total = TotalWidth'(red_sum) + TotalWidth'(green_sum) + TotalWidth'(blue_sum);
      denom = 64'(win_last - win_first) * 64'(win_rows) * 64'd3;
      lhs   = 64'(centre_green_sum) * 64'(ShareScale);
      rhs   = 64'(cfg_threshold) * denom;
      outcome.red_share      = percent_of(red_sum, total);
      outcome.green_share    = percent_of(green_sum, total);
      outcome.blue_share     = percent_of(blue_sum, total);
      outcome.green_centered = (denom != 0) && (lhs > rhs);
      frame_results_due.push_back(outcome);
      red_sum          = '0;
      green_sum        = '0;
      blue_sum         = '0;
      centre_green_sum = '0;
      row_at           = '0;
   endtask

   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int field_mismatch(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want == got) return 0;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         push      <= 1'b0;
         send_wait <= 0;
      end else begin
         if (push && !full) begin
            account_pixel(pixel_backlog.pop_front());
         end
         if (!(push && full)) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               push      <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               push      <= 1'b1;
               req_data  <= pixel_backlog[0];
               send_wait <= pick_gap(send_idle_on);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (stall_request) begin
         hold_left     <= LongHoldCycles;
         stall_request = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop       <= 1'b0;
         take_wait <= 0;
      end else begin
         if (pop && !empty) begin
            if (frame_results_due.size() == 0) begin
               $display("%0t ns: result expected none, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest_due = frame_results_due.pop_front();
               mismatch_count += field_mismatch("red_share", oldest_due.red_share,
                                                rsp_data.red_share);
               mismatch_count += field_mismatch("green_share", oldest_due.green_share,
                                                rsp_data.green_share);
               mismatch_count += field_mismatch("blue_share", oldest_due.blue_share,
                                                rsp_data.blue_share);
               mismatch_count += field_mismatch("green_centered", oldest_due.green_centered,
                                                rsp_data.green_centered);
            end
         end
         if (sink_hold) begin
            pop <= 1'b0;
         end else if (take_wait != 0) begin
            take_wait <= take_wait - 1;
            pop       <= 1'b0;
         end else begin
            pop       <= 1'b1;
            take_wait <= pick_gap(take_idle_on);
         end
      end
   end

   task automatic csr_write(input logic [RegIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_WIDTH:     cfg_width     = value[SizeWidth-1:0];
         REG_HEIGHT:    cfg_height    = value[SizeWidth-1:0];
         REG_THRESHOLD: cfg_threshold = value[ThrWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_pixel(input logic [PixWidth-1:0] r, g, b);
      pixel_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      pixel_backlog.push_back(px);
   endtask

   task automatic queue_random(input int count, input pixel_mix_type mix);
      for (int i = 0; i < count; i++) begin
         case (mix)
            MIX_DIM_GREEN: queue_pixel(PixWidth'($urandom), PixWidth'($urandom_range(0, 3)),
                                       PixWidth'($urandom));
            MIX_DARK:      queue_pixel(8'd0, 8'd0, 8'd0);
            MIX_BRIGHT:    queue_pixel(8'hFF, 8'hFF, 8'hFF);
            default:       queue_pixel(PixWidth'($urandom), PixWidth'($urandom),
                                       PixWidth'($urandom));
         endcase
      end
   endtask

   task automatic settle();
      while (pixel_backlog.size() != 0 || push || frame_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin : stimulus
      int            random_items;
      int            w_size;
      int            h_size;
      int            area;
      int            count;
      int            roll;
      pixel_mix_type mix;
      random_items = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // One pixel per frame, no centre window, zero frame first.
      csr_write(REG_WIDTH, 32'd0);
      csr_write(REG_HEIGHT, 32'd0);
      csr_write(REG_THRESHOLD, 32'd0);
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'hFF, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'hFF, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'hFF);
      queue_pixel(8'd1, 8'h80, 8'hFE);
      settle();

      csr_write(REG_WIDTH, 32'd5);
      csr_write(REG_HEIGHT, 32'd2);
      csr_write(REG_THRESHOLD, ShareScale);
      repeat (5) queue_pixel(8'd0, 8'hFF, 8'd0);
      repeat (5) queue_pixel(8'hFF, 8'd0, 8'hFF);
      settle();

      // Sizes shrink under a frame in progress, which then ends early.
      csr_write(REG_WIDTH, 32'd4);
      csr_write(REG_HEIGHT, 32'd3);
      csr_write(REG_THRESHOLD, 32'h7FFF);
      queue_pixel(8'h80, 8'h7F, 8'h01);
      queue_pixel(8'h55, 8'hAA, 8'h33);
      queue_pixel(8'hCC, 8'h0F, 8'hF0);
      queue_pixel(8'h10, 8'hFE, 8'h20);
      queue_pixel(8'h02, 8'h40, 8'h08);
      settle();
      csr_write(RegSpare, 32'hFFFF_FFFF);
      csr_write(REG_WIDTH, 32'd1);
      csr_write(REG_HEIGHT, 32'd2);
      csr_write(REG_THRESHOLD, 32'd1);
      queue_pixel(8'hFF, 8'h00, 8'h7F);
      queue_pixel(8'h04, 8'hF8, 8'h9C);
      queue_pixel(8'h63, 8'h21, 8'hEE);
      settle();

      while (random_items < RandomItems) begin
         w_size = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
         h_size = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         roll = $urandom_range(0, 9);
         csr_write(REG_WIDTH, w_size);
         csr_write(REG_HEIGHT, h_size);
         csr_write(REG_THRESHOLD, (roll == 0) ? 0 : (roll == 1) ? ShareScale :
                                  (roll == 2) ? 32'h7FFF : $urandom_range(0, ShareScale));
         send_idle_on = ($urandom_range(0, 3) != 0);
         take_idle_on = ($urandom_range(0, 3) != 0);
         area  = (w_size == 0 ? 1 : w_size) * (h_size == 0 ? 1 : h_size);
         count = area * $urandom_range(1, 4);
         if ($urandom_range(0, 2) == 0) count += $urandom_range(0, area - 1);
         roll = $urandom_range(0, 9);
         mix  = (roll < 5) ? MIX_RANDOM : (roll < 8) ? MIX_DIM_GREEN :
                (roll == 8) ? MIX_DARK : MIX_BRIGHT;
         queue_random(count, mix);
         random_items += count;
         settle();
      end

      // Short frames against a stalled result side, so that full rises.
      csr_write(REG_WIDTH, 32'd2);
      csr_write(REG_HEIGHT, 32'd2);
      csr_write(REG_THRESHOLD, $urandom_range(0, ShareScale));
      send_idle_on  = 1'b0;
      take_idle_on  = 1'b1;
      stall_request = 1'b1;
      queue_random(120, MIX_RANDOM);
      settle();

      // Sizes above their limits, shrunk under the frame so that it ends early.
      csr_write(REG_WIDTH, 32'h1FFF);
      csr_write(REG_HEIGHT, 32'h1FFF);
      csr_write(REG_THRESHOLD, $urandom_range(0, ShareScale));
      queue_random(40, MIX_RANDOM);
      settle();
      csr_write(REG_WIDTH, 32'd1);
      csr_write(REG_HEIGHT, 32'd1);
      queue_random(1, MIX_BRIGHT);
      settle();

      if (mismatch_count == 0) begin
         $display("frame_color_density_top verification clean");
      end else begin
         $display("frame_color_density_top verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TimeoutCycles * ClockPeriod);
      $display("frame_color_density_top verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/fcd_pkg.sv
rtl/fcd_csr.sv
rtl/fcd_front.sv
rtl/fcd_queue.sv
rtl/fcd_back.sv
rtl/frame_color_density_top.sv
verif/tb_top.sv
